>>> hw/rtl/tnc_pkg.sv
package tnc_pkg;

    // Sizes of the name window and the fixed patterns.
    localparam int NAME_CAP_DEFAULT = 256;
    localparam int WINDOW           = 8;
    localparam int NUM_PAT          = 9;
    localparam int PAT_BYTES        = WINDOW + 1;
    localparam int META_LEN         = 12;
    localparam int COUNT_W          = 16;

    typedef logic [7:0] byte_t;
    typedef logic [WINDOW-1:0][7:0] window_t;
    typedef logic [PAT_BYTES*8-1:0] pat_text_t;
    typedef logic [3:0] pat_len_t;

    // Result categories.
    typedef enum logic [1:0] {
        CAT_META   = 2'd0,
        CAT_VISION = 2'd1,
        CAT_FLUID  = 2'd2,
        CAT_FROZEN = 2'd3
    } category_t;

    // Pattern hits for the character that just arrived.
    typedef struct packed {
        logic vision;
        logic fluid;
    } match_t;

    // Patterns, last character in the low byte, zero padded above.
    localparam pat_text_t PAT_TEXT [NUM_PAT] = '{
        pat_text_t'("vision"), pat_text_t'("image"), pat_text_t'("patch"),
        pat_text_t'("pre_mm"), pat_text_t'("adapter"), pat_text_t'("vit"),
        pat_text_t'("projector"), pat_text_t'("lora"), pat_text_t'("fluid")
    };
    localparam pat_len_t PAT_LEN [NUM_PAT] = '{
        4'd6, 4'd5, 4'd5, 4'd6, 4'd7, 4'd3, 4'd9, 4'd4, 4'd5
    };
    localparam logic [NUM_PAT-1:0] PAT_IS_VISION = 9'b0_0111_1111;

    localparam logic [META_LEN*8-1:0] META_TEXT = "__metadata__";

    // Byte mask covering the low len bytes of a pattern.
    function automatic pat_text_t pat_mask(input pat_len_t len);
        pat_text_t m;
        m = '0;
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            if (pat_len_t'(i) < len)
            begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Character of the metadata name at a given position, zero past its end.
    function automatic byte_t meta_char(input logic [3:0] idx);
        byte_t c;
        c = '0;
        for (int i = 0; i < META_LEN; i++)
        begin
            if (idx == 4'(i))
            begin
                c = META_TEXT[8*(META_LEN-1-i) +: 8];
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/tensor_name_classifier_core.sv
// Channel  Handshake                  Payload
// item     item_valid / item_stall    name_char, char_present, end_of_name
// result   result_valid / result_stall category, vision_total, fluid_total
//
// One character is taken every cycle while item_stall is low. The result register
// loads when the character that ends its name leaves the input register.
// The rate is set by the input register feeding the parallel pattern compare,
// which folds one character into the name state per cycle unless an end item waits.
// Reset (rst_n low) empties both registers and clears the name state and totals.
// A stalled result holds the result register; the input register then holds
// only an end-of-name item, and item_stall rises until the result slot frees.
module tensor_name_classifier_core #(
    parameter int NAME_CAP = tnc_pkg::NAME_CAP_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  tnc_pkg::byte_t                  name_char,
    input  logic                            char_present,
    input  logic                            end_of_name,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [1:0]                      category,
    output logic [tnc_pkg::COUNT_W-1:0]     vision_total,
    output logic [tnc_pkg::COUNT_W-1:0]     fluid_total
);
    import tnc_pkg::*;

    localparam int POS_W = $clog2(NAME_CAP);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(NAME_CAP - 1);
    localparam logic [POS_W-1:0] POS_META  = POS_W'(META_LEN);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Input register.
    logic  s1_valid_reg, s1_valid_next;
    byte_t s1_char_reg;
    logic  s1_present_reg;
    logic  s1_end_reg;

    // Per-name state.
    window_t          recent_reg, recent_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             ended_reg, ended_next;
    logic             meta_reg, meta_next;
    logic             vis_seen_reg, vis_seen_next;
    logic             fluid_seen_reg, fluid_seen_next;
    logic [COUNT_W-1:0] vis_cnt_reg, vis_cnt_next;
    logic [COUNT_W-1:0] fluid_cnt_reg, fluid_cnt_next;

    // Result register.
    logic      out_valid_reg, out_valid_next;
    category_t cat_reg, cat_next;
    logic [COUNT_W-1:0] vis_out_reg;
    logic [COUNT_W-1:0] fluid_out_reg;

    match_t hits;
    logic   item_xfer;
    logic   out_free;
    logic   s1_adv;
    logic   emit;
    logic   eligible;
    logic   take;
    logic   vis_now, fluid_now, meta_now;
    logic [POS_W-1:0] pos_now;

    tnc_match u_match (
        .cur_char (s1_char_reg),
        .recent   (recent_reg),
        .hits     (hits)
    );

    // Flow control: a plain character always moves on, an ending one needs the result slot.
    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_adv     = s1_valid_reg && (!s1_end_reg || out_free);
    assign emit       = s1_adv && s1_end_reg;
    assign item_stall = s1_valid_reg && !s1_adv;
    assign item_xfer  = item_valid && !item_stall;

    assign s1_valid_next  = item_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = emit ? 1'b1 : (out_valid_reg && result_stall);

    // Fold the registered character into the name state.
    always_comb
    begin
        eligible  = s1_present_reg && !ended_reg && (pos_reg < POS_LIMIT);
        take      = eligible && (s1_char_reg != 8'd0);
        vis_now   = vis_seen_reg || (take && hits.vision);
        fluid_now = fluid_seen_reg || (take && hits.fluid);
        meta_now  = meta_reg && !(take && ((pos_reg >= POS_META) ||
                    (meta_char(pos_reg[3:0]) != s1_char_reg)));
        pos_now   = pos_reg + POS_W'(take);

        recent_next     = recent_reg;
        pos_next        = pos_reg;
        ended_next      = ended_reg;
        meta_next       = meta_reg;
        vis_seen_next   = vis_seen_reg;
        fluid_seen_next = fluid_seen_reg;
        vis_cnt_next    = vis_cnt_reg;
        fluid_cnt_next  = fluid_cnt_reg;
        cat_next        = CAT_FROZEN;

        if (meta_now && (pos_now == POS_META))
        begin
            cat_next = CAT_META;
        end
        else if (vis_now)
        begin
            cat_next = CAT_VISION;
        end
        else if (fluid_now)
        begin
            cat_next = CAT_FLUID;
        end

        if (s1_adv)
        begin
            if (s1_end_reg)
            begin
                // Name closes: bump a total and return to the empty-name state.
                if (cat_next == CAT_VISION && vis_cnt_reg != COUNT_MAX)
                begin
                    vis_cnt_next = vis_cnt_reg + 1'b1;
                end
                if (cat_next == CAT_FLUID && fluid_cnt_reg != COUNT_MAX)
                begin
                    fluid_cnt_next = fluid_cnt_reg + 1'b1;
                end
                recent_next     = '0;
                pos_next        = '0;
                ended_next      = 1'b0;
                meta_next       = 1'b1;
                vis_seen_next   = 1'b0;
                fluid_seen_next = 1'b0;
            end
            else
            begin
                pos_next        = pos_now;
                meta_next       = meta_now;
                vis_seen_next   = vis_now;
                fluid_seen_next = fluid_now;
                ended_next      = ended_reg || (eligible && s1_char_reg == 8'd0);
                if (take)
                begin
                    recent_next = {recent_reg[WINDOW-2:0], s1_char_reg};
                end
            end
        end
    end

    // Control and name state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            recent_reg     <= '0;
            pos_reg        <= '0;
            ended_reg      <= 1'b0;
            meta_reg       <= 1'b1;
            vis_seen_reg   <= 1'b0;
            fluid_seen_reg <= 1'b0;
            vis_cnt_reg    <= '0;
            fluid_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            recent_reg     <= recent_next;
            pos_reg        <= pos_next;
            ended_reg      <= ended_next;
            meta_reg       <= meta_next;
            vis_seen_reg   <= vis_seen_next;
            fluid_seen_reg <= fluid_seen_next;
            vis_cnt_reg    <= vis_cnt_next;
            fluid_cnt_reg  <= fluid_cnt_next;
        end
    end

    // Payload registers load only on a transfer in or a new result.
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            s1_char_reg    <= name_char;
            s1_present_reg <= char_present;
            s1_end_reg     <= end_of_name;
        end
        if (emit)
        begin
            cat_reg       <= cat_next;
            vis_out_reg   <= vis_cnt_next;
            fluid_out_reg <= fluid_cnt_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign category     = cat_reg;
    assign vision_total = vis_out_reg;
    assign fluid_total  = fluid_out_reg;

    // A metadata name leaves both totals untouched.
    a_meta_keeps_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cat_next == CAT_META) |=> ($stable(vis_cnt_reg) && $stable(fluid_cnt_reg)))
        else $error("totals changed on a metadata name");

    // Closing a name returns the per-name state to empty.
    a_name_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (pos_reg == '0 && meta_reg && !vis_seen_reg && !fluid_seen_reg
                  && !ended_reg && recent_reg == '0))
        else $error("name state not cleared after a result");

    // The character count never passes the name limit.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LIMIT)
        else $error("character position beyond the name limit");

    // An item held in the input register is never dropped.
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_end_reg)))
        else $error("held input item lost");

endmodule

>>> hw/rtl/tnc_match.sv
module tnc_match (
    input  tnc_pkg::byte_t   cur_char,
    input  tnc_pkg::window_t recent,
    output tnc_pkg::match_t  hits
);
    import tnc_pkg::*;

    pat_text_t          win;
    logic [NUM_PAT-1:0] pat_hit;

    // The newest character sits in the low byte, older ones above it.
    assign win = {recent, cur_char};

    // Every pattern is compared against the window in parallel.
    always_comb
    begin
        for (int p = 0; p < NUM_PAT; p++)
        begin
            pat_hit[p] = ((win ^ PAT_TEXT[p]) & pat_mask(PAT_LEN[p])) == '0;
        end
    end

    assign hits.vision = |(pat_hit & PAT_IS_VISION);
    assign hits.fluid  = |(pat_hit & ~PAT_IS_VISION);

endmodule
